@@ hdl/smpl_pkg.sv @@
package smpl_pkg;

  // one tick transaction
  typedef struct packed {
    logic signed [31:0] reference;
    logic signed [31:0] synergy_position;
    logic [23:0]        time_step;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic signed [31:0] drive_torque;
    logic signed [31:0] tendon_torque;
    logic signed [31:0] motor_position;
    logic signed [31:0] motor_velocity;
    logic signed [31:0] motor_effort;
    logic               at_limit;
  } out_t;

  // register indexes
  localparam logic [3:0] REG_PROP_GAIN   = 4'd0;
  localparam logic [3:0] REG_INTEG_GAIN  = 4'd1;
  localparam logic [3:0] REG_DERIV_GAIN  = 4'd2;
  localparam logic [3:0] REG_TORQUE_LIM  = 4'd3;
  localparam logic [3:0] REG_TENDON_K    = 4'd4;
  localparam logic [3:0] REG_FRICTION    = 4'd5;
  localparam logic [3:0] REG_DAMPING     = 4'd6;
  localparam logic [3:0] REG_INV_INERTIA = 4'd7;

  localparam logic signed [31:0] REF_LIMIT  = 32'sd1638400;
  localparam logic [10:0]        FRIC_STIFF = 11'd1000;
  localparam int                 MUL_STEPS  = 31;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ hdl/smpl_mul.sv @@
module smpl_mul
  import smpl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic [30:0]        b,
  output logic               done,
  output logic signed [63:0] prod
);

  localparam int CW = $clog2(MUL_STEPS);

  logic signed [32:0] hi_r;
  logic [30:0]        lo_r;
  logic signed [31:0] a_r;
  logic [CW-1:0]      cnt_r;
  logic               run_r;
  logic               done_r;
  logic signed [33:0] sum;

  // one multiplier bit per cycle, lsb first
  assign sum = 34'(hi_r) + (lo_r[0] ? 34'(a_r) : 34'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        hi_r  <= '0;
        lo_r  <= b;
        a_r   <= a;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        hi_r <= sum[33:1];
        lo_r <= {sum[0], lo_r[30:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

@@ hdl/synergy_motor_position_loop_top.sv @@
// PID position loop with a DC motor model, one result per tick transaction.
// The nine products of a tick share one bit-serial multiplier; the friction
// spring term (times 1000) is built from shifts. A product is launched, runs
// its 31 shift-add steps and then reports done. A tick runs the nine products
// in sequence, and after the last one the result is loaded into the output
// register. The motor position is committed in that same cycle, and the next
// tick can be accepted in the cycle after that. While the previous result is
// still stalled at the output, the tick waits after its last product and the
// input stays stalled. The friction slip bound is found by a bit-serial divide
// by 1000. It runs alongside the first products. No clearing pass: the loop
// state (integrator, position, velocity, friction anchor) resets at once.
module synergy_motor_position_loop_top
  import smpl_pkg::*;
#(
  parameter logic signed [31:0] MIN_POSITION = 32'sd0,
  parameter logic signed [31:0] MAX_POSITION = 32'sd1638400
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    OP_KI_ERR, OP_INT_DT, OP_KP_ERR, OP_KD_DERR, OP_TENDON,
    OP_DAMP, OP_INERTIA, OP_ACC_DT, OP_VEL_DT
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [30:0] kp_r, ki_r, kd_r, tmax_r, ktend_r, tfric_r, damp_r, invj_r;

  logic signed [31:0] integ_r, pos_r, vel_r, anchor_r;
  logic signed [31:0] err_r, derr_r, pdiff_r, tmp_r;
  logic signed [31:0] drive_r, tendon_r, fric_r, effort_r;
  logic signed [49:0] pid_acc_r;
  logic [23:0]        dt_r;
  logic               start_r;
  out_t               res_r;
  logic               out_valid_r;

  // slip bound divider
  logic [30:0] div_r;
  logic [9:0]  rem_r;
  logic [4:0]  div_cnt_r;
  logic        div_run_r;
  logic [10:0] div_try;
  logic        div_ge;

  logic signed [31:0] mul_a;
  logic [30:0]        mul_b;
  logic               mul_done;
  logic signed [63:0] prod;
  logic signed [47:0] p16;
  logic signed [39:0] p24;

  logic signed [31:0] ref_c;
  logic signed [63:0] pid64, diff, off64, anc_new, pa, eff64, pos64;
  logic signed [31:0] pid_s, anc_s, pos_s;

  smpl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign p16 = prod[63:16];
  assign p24 = prod[63:24];

  // operand selection per product
  always_comb begin
    unique case (op_r)
      OP_KI_ERR:  begin mul_a = err_r;    mul_b = ki_r;           end
      OP_INT_DT:  begin mul_a = tmp_r;    mul_b = 31'(dt_r);      end
      OP_KP_ERR:  begin mul_a = err_r;    mul_b = kp_r;           end
      OP_KD_DERR: begin mul_a = derr_r;   mul_b = kd_r;           end
      OP_TENDON:  begin mul_a = pdiff_r;  mul_b = ktend_r;        end
      OP_DAMP:    begin mul_a = vel_r;    mul_b = damp_r;         end
      OP_INERTIA: begin mul_a = effort_r; mul_b = invj_r;         end
      OP_ACC_DT:  begin mul_a = tmp_r;    mul_b = 31'(dt_r);      end
      OP_VEL_DT:  begin mul_a = vel_r;    mul_b = 31'(dt_r);      end
      default:    begin mul_a = '0;       mul_b = '0;             end
    endcase
  end

  // reference clamp
  always_comb begin
    ref_c = in_data.reference;
    if (ref_c > REF_LIMIT) ref_c = REF_LIMIT;
    if (ref_c < -REF_LIMIT) ref_c = -REF_LIMIT;
  end

  // pid sum and drive saturation inputs
  assign pid64 = 64'(pid_acc_r) + 64'(p16);
  assign pid_s = sat32(pid64);

  // friction anchor slip and spring term
  assign off64 = 64'(signed'({1'b0, div_r}));
  assign diff  = 64'(pos_r) - 64'(anchor_r);
  always_comb begin
    anc_new = 64'(anchor_r);
    if (diff < -off64) anc_new = 64'(pos_r) + off64;
    else if (diff > off64) anc_new = 64'(pos_r) - off64;
  end
  assign anc_s = sat32(anc_new);
  assign pa    = 64'(pos_r) - 64'(anc_s);

  assign eff64 = 64'(drive_r) + 64'(tendon_r) + 64'(fric_r) - 64'(p16);
  assign pos64 = 64'(pos_r) + 64'(p24);
  assign pos_s = sat32(pos64);

  assign div_try = {rem_r, div_r[30]};
  assign div_ge  = (div_try >= FRIC_STIFF);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= 31'd655360;
      ki_r    <= 31'd0;
      kd_r    <= 31'd32768;
      tmax_r  <= 31'd98304;
      ktend_r <= 31'd6553600;
      tfric_r <= 31'd0;
      damp_r  <= 31'd0;
      invj_r  <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   kp_r    <= cfg_data[30:0];
        REG_INTEG_GAIN:  ki_r    <= cfg_data[30:0];
        REG_DERIV_GAIN:  kd_r    <= cfg_data[30:0];
        REG_TORQUE_LIM:  tmax_r  <= cfg_data[30:0];
        REG_TENDON_K:    ktend_r <= cfg_data[30:0];
        REG_FRICTION:    tfric_r <= cfg_data[30:0];
        REG_DAMPING:     damp_r  <= cfg_data[30:0];
        REG_INV_INERTIA: invj_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_KI_ERR;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      div_run_r   <= 1'b0;
      div_cnt_r   <= '0;
      integ_r     <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      anchor_r    <= '0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // divider steps
      if (div_run_r) begin
        rem_r     <= div_ge ? 10'(div_try - FRIC_STIFF) : div_try[9:0];
        div_r     <= {div_r[29:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == 5'd30) div_run_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            err_r     <= sat32(64'(ref_c) - 64'(pos_r));
            derr_r    <= sat32(-64'(vel_r));
            pdiff_r   <= sat32(64'(pos_r) - 64'(in_data.synergy_position));
            dt_r      <= in_data.time_step;
            op_r      <= OP_KI_ERR;
            start_r   <= 1'b1;
            div_r     <= tfric_r;
            rem_r     <= '0;
            div_cnt_r <= '0;
            div_run_r <= 1'b1;
            state_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mul_done) begin
            start_r <= 1'b1;
            unique case (op_r)
              OP_KI_ERR: begin
                tmp_r <= sat32(64'(p16));
                op_r  <= OP_INT_DT;
              end
              OP_INT_DT: begin
                integ_r <= sat32(64'(integ_r) + 64'(p24));
                op_r    <= OP_KP_ERR;
              end
              OP_KP_ERR: begin
                pid_acc_r <= 50'(integ_r) + 50'(p16);
                op_r      <= OP_KD_DERR;
              end
              OP_KD_DERR: begin
                if (65'(pid_s) > 65'(signed'({1'b0, tmax_r})))
                  drive_r <= signed'({1'b0, tmax_r});
                else if (65'(pid_s) < -65'(signed'({1'b0, tmax_r})))
                  drive_r <= -signed'({1'b0, tmax_r});
                else
                  drive_r <= pid_s;
                op_r <= OP_TENDON;
              end
              OP_TENDON: begin
                tendon_r <= sat32(64'(p16));
                anchor_r <= anc_s;
                fric_r   <= sat32((pa <<< 10) - (pa <<< 4) - (pa <<< 3));
                op_r     <= OP_DAMP;
              end
              OP_DAMP: begin
                effort_r <= sat32(eff64);
                op_r     <= OP_INERTIA;
              end
              OP_INERTIA: begin
                tmp_r <= sat32(64'(p16));
                op_r  <= OP_ACC_DT;
              end
              OP_ACC_DT: begin
                vel_r <= sat32(64'(vel_r) + 64'(p24));
                op_r  <= OP_VEL_DT;
              end
              OP_VEL_DT: begin
                // last product stays in the multiplier until the output is free
                start_r <= 1'b0;
                state_r <= ST_WAIT;
              end
              default: ;
            endcase
          end
        end
        ST_WAIT: begin
          // position update and result load once the output register is free
          if (!out_valid_r || !out_stall) begin
            res_r.drive_torque  <= drive_r;
            res_r.tendon_torque <= tendon_r;
            if (pos_s < MIN_POSITION || pos_s > MAX_POSITION) begin
              pos_r <= (pos_s < MIN_POSITION) ? MIN_POSITION : MAX_POSITION;
              vel_r <= '0;
              res_r.motor_position <= (pos_s < MIN_POSITION) ? MIN_POSITION
                                                             : MAX_POSITION;
              res_r.motor_velocity <= '0;
              res_r.motor_effort   <= '0;
              res_r.at_limit       <= 1'b1;
            end else begin
              pos_r <= pos_s;
              res_r.motor_position <= pos_s;
              res_r.motor_velocity <= vel_r;
              res_r.motor_effort   <= effort_r;
              res_r.at_limit       <= 1'b0;
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
